@@ rtl/tifp_pkg.sv @@
// Shared constants, types and helper functions of the tagged integer ALU.
package tifp_pkg;

    localparam int INT_BITS = 63;
    localparam int DW       = 64;
    localparam int OUT_W    = 63;
    localparam int NCELL    = DW;

    typedef logic [3:0] t_act;
    localparam t_act ACT_ADD    = 4'd0;
    localparam t_act ACT_SUB    = 4'd1;
    localparam t_act ACT_MUL    = 4'd2;
    localparam t_act ACT_DIV    = 4'd3;
    localparam t_act ACT_MOD    = 4'd4;
    localparam t_act ACT_AND    = 4'd5;
    localparam t_act ACT_OR     = 4'd6;
    localparam t_act ACT_XOR    = 4'd7;
    localparam t_act ACT_EQ     = 4'd8;
    localparam t_act ACT_NE     = 4'd9;
    localparam t_act ACT_LT     = 4'd10;
    localparam t_act ACT_LE     = 4'd11;
    localparam t_act ACT_GT     = 4'd12;
    localparam t_act ACT_GE     = 4'd13;
    localparam t_act ACT_TRUTHY = 4'd14;

    typedef logic [1:0] t_status;
    localparam t_status ST_INT  = 2'd0;
    localparam t_status ST_BOOL = 2'd1;
    localparam t_status ST_SLOW = 2'd2;

    localparam logic [DW-1:0] HALF = DW'(1) << (INT_BITS - 1);

    typedef struct packed {
        t_act             action;
        logic             lhs_is_int;
        logic             lhs_is_null;
        logic [DW-1:0]    lhs_value;
        logic             rhs_is_int;
        logic [DW-1:0]    rhs_value;
    } t_in;

    typedef struct packed {
        t_act             action;
        logic             both;
        logic             an;
        logic             bn;
        t_status          f_status;
        logic [OUT_W-1:0] f_int;
        logic             f_bool;
        logic [DW-1:0]    ub;
        logic [DW-1:0]    rem;
        logic [DW-1:0]    dq;
        logic             mul_ovf;
        logic [DW-1:0]    mul_mag;
    } t_word;

    function automatic logic fits_pat(input logic [DW-1:0] r);
        return (&r[DW-1:INT_BITS-1]) | ~(|r[DW-1:INT_BITS-1]);
    endfunction

    function automatic logic fits_sm(input logic neg, input logic [DW-1:0] mag);
        return neg ? (mag <= HALF) : (mag <= HALF - DW'(1));
    endfunction

endpackage

@@ rtl/tifp_in_if.sv @@
// Input channel: operation and two decoded operands.
interface tifp_in_if;
    import tifp_pkg::*;
    logic          valid;
    logic          ready;
    t_act          action;
    logic          lhs_is_int;
    logic          lhs_is_null;
    logic [DW-1:0] lhs_value;
    logic          rhs_is_int;
    logic [DW-1:0] rhs_value;

    modport source (output valid, action, lhs_is_int, lhs_is_null, lhs_value,
                    rhs_is_int, rhs_value, input ready);
    modport sink (input valid, action, lhs_is_int, lhs_is_null, lhs_value,
                  rhs_is_int, rhs_value, output ready);
endinterface

@@ rtl/tifp_out_if.sv @@
// Output channel: status, integer result and boolean result.
interface tifp_out_if;
    import tifp_pkg::*;
    logic             valid;
    logic             ready;
    t_status          status;
    logic [OUT_W-1:0] int_result;
    logic             bool_result;

    modport source (output valid, status, int_result, bool_result, input ready);
    modport sink (input valid, status, int_result, bool_result, output ready);
endinterface

@@ rtl/tifp_front.sv @@
// Front stages: operand decode, fast ops, partial products, product sum.
module tifp_front
    import tifp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_in   i_item,
    output logic  o_valid,
    output t_word o_word
);

    logic          lnull, lint, rint, both, an, bn, ok, eqw;
    logic [DW-1:0] a, b, ua, ub, r, sum, dif;
    t_status       st;
    logic          bres;

    always_comb begin
        a     = i_item.lhs_value;
        b     = i_item.rhs_value;
        lnull = i_item.lhs_is_null;
        lint  = i_item.lhs_is_int & ~lnull;
        rint  = i_item.rhs_is_int;
        both  = lint & rint;
        an    = a[DW-1];
        bn    = b[DW-1];
        ua    = an ? (DW'(0) - a) : a;
        ub    = bn ? (DW'(0) - b) : b;
        sum   = a + b;
        dif   = a - b;
        eqw   = (lint == rint) && (a == b);
        ok    = 1'b0;
        r     = '0;
        st    = ST_SLOW;
        bres  = 1'b0;
        case (i_item.action)
            ACT_ADD: begin
                r  = sum;
                ok = both && !(an == bn && sum[DW-1] != an) && fits_pat(sum);
            end
            ACT_SUB: begin
                r  = dif;
                ok = both && !(an != bn && dif[DW-1] != an) && fits_pat(dif);
            end
            ACT_AND: begin
                r  = a & b;
                ok = both && fits_pat(r);
            end
            ACT_OR: begin
                r  = a | b;
                ok = both && fits_pat(r);
            end
            ACT_XOR: begin
                r  = a ^ b;
                ok = both && fits_pat(r);
            end
            ACT_EQ, ACT_NE: begin
                if (eqw) begin
                    st   = ST_BOOL;
                    bres = (i_item.action == ACT_EQ);
                end else if (both) begin
                    st   = ST_BOOL;
                    bres = (i_item.action == ACT_NE);
                end
            end
            ACT_LT, ACT_LE, ACT_GT, ACT_GE: begin
                if (both) begin
                    st = ST_BOOL;
                    case (i_item.action)
                        ACT_LT:  bres = $signed(a) <  $signed(b);
                        ACT_LE:  bres = $signed(a) <= $signed(b);
                        ACT_GT:  bres = $signed(a) >  $signed(b);
                        default: bres = $signed(a) >= $signed(b);
                    endcase
                end
            end
            ACT_TRUTHY: begin
                if (lnull) begin
                    st = ST_BOOL;
                end else if (lint) begin
                    st   = ST_BOOL;
                    bres = (a != '0);
                end
            end
            default: ;
        endcase
        if (ok) begin
            st = ST_INT;
        end
    end

    logic          r1_valid, r2_valid, r3_valid;
    t_word         r1_word, r2_word, r3_word;
    t_word         n_word;
    logic [DW-1:0] r2_ll, r2_lh, r2_hl, r2_hh;
    logic [2*DW-1:0] prod;

    always_comb begin
        prod = {r2_hh, r2_ll} + ({{DW{1'b0}}, r2_lh} << (DW / 2))
                              + ({{DW{1'b0}}, r2_hl} << (DW / 2));
        n_word         = r2_word;
        n_word.mul_ovf = |prod[2*DW-1:DW];
        n_word.mul_mag = prod[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_word.action   <= i_item.action;
            r1_word.both     <= both;
            r1_word.an       <= an;
            r1_word.bn       <= bn;
            r1_word.f_status <= st;
            r1_word.f_int    <= (st == ST_INT) ? r[OUT_W-1:0] : '0;
            r1_word.f_bool   <= (st == ST_BOOL) ? bres : 1'b0;
            r1_word.ub       <= ub;
            r1_word.rem      <= '0;
            r1_word.dq       <= ua;
            r1_word.mul_ovf  <= 1'b0;
            r1_word.mul_mag  <= '0;

            r2_word <= r1_word;
            r2_ll <= r1_word.dq[DW/2-1:0]  * r1_word.ub[DW/2-1:0];
            r2_lh <= r1_word.dq[DW/2-1:0]  * r1_word.ub[DW-1:DW/2];
            r2_hl <= r1_word.dq[DW-1:DW/2] * r1_word.ub[DW/2-1:0];
            r2_hh <= r1_word.dq[DW-1:DW/2] * r1_word.ub[DW-1:DW/2];

            r3_word <= n_word;
        end
    end

    assign o_valid = r3_valid;
    assign o_word  = r3_word;

endmodule

@@ rtl/tifp_div_cell.sv @@
// One restoring division cell: produces one quotient bit and passes the word on.
module tifp_div_cell
    import tifp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_word i_word,
    output logic  o_valid,
    output t_word o_word
);

    logic [DW:0]   t, d;
    logic          ge;
    t_word         n_word;
    logic          r_valid;
    t_word         r_word;

    always_comb begin
        t      = {i_word.rem, i_word.dq[DW-1]};
        d      = t - {1'b0, i_word.ub};
        ge     = t >= {1'b0, i_word.ub};
        n_word = i_word;
        n_word.rem = ge ? d[DW-1:0] : t[DW-1:0];
        n_word.dq  = {i_word.dq[DW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ rtl/tifp_back.sv @@
// Result stage: floor adjust, range check, result select and output register.
module tifp_back
    import tifp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_word            i_word,
    output logic             o_valid,
    output t_status          o_status,
    output logic [OUT_W-1:0] o_int,
    output logic             o_bool
);

    logic          neg, dz, ok, rnz, mneg;
    logic [DW-1:0] mag, r, qm, rm;
    t_status       st;
    logic          bres;
    logic [OUT_W-1:0] ires;

    always_comb begin
        neg  = i_word.an ^ i_word.bn;
        dz   = (i_word.ub == '0);
        rnz  = (i_word.rem != '0);
        qm   = i_word.dq + DW'(neg && rnz);
        rm   = (rnz && neg) ? (i_word.ub - i_word.rem) : i_word.rem;
        mneg = i_word.bn && (rm != '0);
        ok   = 1'b0;
        mag  = '0;
        r    = '0;
        st   = i_word.f_status;
        ires = i_word.f_int;
        bres = i_word.f_bool;
        case (i_word.action)
            ACT_MUL: begin
                mag = i_word.mul_mag;
                ok  = i_word.both && !i_word.mul_ovf && fits_sm(neg, mag);
                r   = neg ? (DW'(0) - mag) : mag;
            end
            ACT_DIV: begin
                mag = qm;
                ok  = i_word.both && !dz && fits_sm(neg, mag);
                r   = neg ? (DW'(0) - mag) : mag;
            end
            ACT_MOD: begin
                mag = rm;
                ok  = i_word.both && !dz && fits_sm(mneg, mag);
                r   = mneg ? (DW'(0) - mag) : mag;
            end
            default: ;
        endcase
        if (i_word.action == ACT_MUL || i_word.action == ACT_DIV
                || i_word.action == ACT_MOD) begin
            st   = ok ? ST_INT : ST_SLOW;
            ires = ok ? r[OUT_W-1:0] : '0;
            bres = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_status <= st;
            o_int    <= ires;
            o_bool   <= bres;
        end
    end

endmodule

@@ rtl/tagged_int_fast_path_alu_core.sv @@
// Top level of the tagged small-integer fast path ALU.
// Pipeline: 68 register stages between the accepting edge and result valid
// (3 front stages, 64 division cells, 1 output register); every op travels the full chain.
// Throughput: one word per cycle; the whole chain stalls only while a result
// waits at the output and the sink is not ready.
// Reset: synchronous, active low; clears all stage valid bits.
module tagged_int_fast_path_alu_core
    import tifp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tifp_in_if.sink   i_in,
    tifp_out_if.source o_out
);

    logic  en;
    t_in   item;
    logic  v [0:NCELL];
    t_word w [0:NCELL];

    assign en         = ~o_out.valid | o_out.ready;
    assign i_in.ready = en;

    assign item = {i_in.action, i_in.lhs_is_int, i_in.lhs_is_null, i_in.lhs_value,
                   i_in.rhs_is_int, i_in.rhs_value};

    tifp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_item  (item),
        .o_valid (v[0]),
        .o_word  (w[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        tifp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_word  (w[g]),
            .o_valid (v[g+1]),
            .o_word  (w[g+1])
        );
    end

    tifp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (v[NCELL]),
        .i_word   (w[NCELL]),
        .o_valid  (o_out.valid),
        .o_status (o_out.status),
        .o_int    (o_out.int_result),
        .o_bool   (o_out.bool_result)
    );

endmodule

@@ rtl/tifp_chk.sv @@
// Port-level checker for the tagged integer ALU, bound to the top level.
module tifp_chk
    import tifp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input t_status          i_status,
    input logic [OUT_W-1:0] i_int,
    input logic             i_bool
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_INT || i_status == ST_BOOL
                         || i_status == ST_SLOW))
        else $error("bad status code");

    a_int_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_INT) |-> (i_int == '0))
        else $error("integer result not cleared");

    a_bool_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_BOOL) |-> !i_bool)
        else $error("boolean result not cleared");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while output stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
                                           && $stable(i_int)))
        else $error("stalled result changed");

endmodule

bind tagged_int_fast_path_alu_core tifp_chk u_tifp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_int       (o_out.int_result),
    .i_bool      (o_out.bool_result)
);
